// ===== hdl/lag_pkg.sv =====
`timescale 1ns / 1ps
package lag_pkg;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 7;
	localparam int COORD_W = 6;

	localparam logic [1:0] FN_WRITE  = 2'd0;
	localparam logic [1:0] FN_READ   = 2'd1;
	localparam logic [1:0] FN_STEP   = 2'd2;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_WRAP_EDGES  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CAPT,
		ST_SWEEP,
		ST_FINISH
	} state_t;

endpackage

// ===== hdl/life_automaton_grid.sv =====
`timescale 1ns / 1ps
// B3/S23 life grid held as a ring of MAX_HEIGHT row registers; while a pass runs the ring rotates
// by one row per cycle. A write or read with coordinates in range makes one full rotation of the
// ring before its result; an out-of-range access or an unused function code goes straight to it.
// A generation step makes two rotations: one captures the first and last
// active rows for the vertical edges, a second computes each new row from a three-row window
// at the head of the ring and feeds it in at the tail. One item is worked on at a time; a
// finished result waits in the output register.
module life_automaton_grid #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [5:0]                 cell_x,
	input  logic [5:0]                 cell_y,
	input  logic                       cell_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       cell_alive,
	output logic                       coord_error,
	input  logic                       cfg_we,
	input  logic [lag_pkg::CFG_IW-1:0] cfg_index,
	input  logic [lag_pkg::CFG_DW-1:0] cfg_wdata
);
	import lag_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int RST_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
	localparam int RST_H = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic          wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		int cv;
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= HW'(RST_H);
			wrap_q   <= 1'b0;
		end else if (cfg_we) begin
			cv = int'(cfg_wdata);
			case (cfg_index)
				REG_GRID_WIDTH: begin
					width_q <= (cv == 0) ? WW'(1) :
						(cv > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cv);
				end
				REG_GRID_HEIGHT: begin
					height_q <= (cv == 0) ? HW'(1) :
						(cv > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cv);
				end
				REG_WRAP_EDGES: begin
					wrap_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	state_t         state_q, state_d;
	logic [RW-1:0]  idx_q;
	logic [1:0]     func_q;
	logic [5:0]     x_q, y_q;
	logic           v_q;
	logic           res_alive_q, res_err_q;
	logic           out_valid_q, alive_q, err_q;
	logic           shift, load_res, last, hit, accept, bad_in, access_in;
	logic [MAX_WIDTH-1:0] rows [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] prev_q, row0_q, last_q;
	logic [MAX_WIDTH-1:0] xmask, tail_d, above, below, next_row;

	assign accept    = in_valid && !in_stall;
	assign bad_in    = (32'(cell_x) >= 32'(width_q)) || (32'(cell_y) >= 32'(height_q));
	assign access_in = (func == FN_WRITE) || (func == FN_READ);
	assign last      = (idx_q == RW'(MAX_HEIGHT - 1));
	assign hit       = (32'(idx_q) == 32'(y_q));

	always_comb begin
		state_d  = state_q;
		shift    = 1'b0;
		load_res = 1'b0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func == FN_STEP) begin
						state_d = ST_CAPT;
					end else if (access_in && !bad_in) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_CAPT: begin
				shift = 1'b1;
				if (last) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				shift = 1'b1;
				if (last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift) begin
				idx_q <= last ? '0 : idx_q + RW'(1);
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= func;
			x_q         <= cell_x;
			y_q         <= cell_y;
			v_q         <= cell_value;
			res_err_q   <= access_in && bad_in;
			res_alive_q <= (func == FN_WRITE) && !bad_in && cell_value;
		end else if (state_q == ST_SWEEP && hit && func_q == FN_READ) begin
			res_alive_q <= |(rows[0] & xmask);
		end
		if (shift) begin
			prev_q <= rows[0];
		end
		if (state_q == ST_CAPT && idx_q == '0) begin
			row0_q <= rows[0];
		end
		if (state_q == ST_CAPT && 32'(idx_q) == 32'(height_q) - 32'd1) begin
			last_q <= rows[0];
		end
		if (load_res) begin
			alive_q <= res_alive_q;
			err_q   <= res_err_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			xmask[i] = (32'(x_q) == i);
		end
	end

	// window around the head row; vertical edges come from the captured rows when wrapping, else zero
	always_comb begin
		if (idx_q == '0) begin
			above = wrap_q ? last_q : '0;
		end else begin
			above = prev_q;
		end
		if (32'(idx_q) == 32'(height_q) - 32'd1) begin
			below = wrap_q ? row0_q : '0;
		end else begin
			below = rows[1];
		end
	end

	lag_rule #(.W(MAX_WIDTH)) u_rule (
		.above (above),
		.mid   (rows[0]),
		.below (below),
		.width (width_q),
		.wrap  (wrap_q),
		.next  (next_row)
	);

	always_comb begin
		tail_d = rows[0];
		if (state_q == ST_SWEEP) begin
			if (func_q == FN_STEP) begin
				tail_d = (32'(idx_q) < 32'(height_q)) ? next_row : '0;
			end else if (func_q == FN_WRITE && hit) begin
				tail_d = (rows[0] & ~xmask) | ({MAX_WIDTH{v_q}} & xmask);
			end
		end
	end

	for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_row
		lag_row_cell #(.W(MAX_WIDTH)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      ((i == MAX_HEIGHT - 1) ? tail_d : rows[(i + 1) % MAX_HEIGHT]),
			.row    (rows[i])
		);
	end

	assign out_valid   = out_valid_q;
	assign cell_alive  = alive_q;
	assign coord_error = err_q;

	a_step_capt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FN_STEP |=> state_q == ST_CAPT)
		else $error("step transfer did not start the capture pass");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> idx_q == '0)
		else $error("row counter not back at zero when idle");
	a_err_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(alive_q && err_q))
		else $error("coordinate error reported with a live cell");
	a_no_shift_idle: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> (state_q == ST_CAPT || state_q == ST_SWEEP))
		else $error("ring rotated outside a pass");
endmodule

// ===== hdl/lag_row_cell.sv =====
`timescale 1ns / 1ps
// One grid row; takes the row of its neighbour on every shift.
module lag_row_cell #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] row
);
	logic [W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift) begin
			row_q <= d;
		end
	end

	assign row = row_q;
endmodule

// ===== hdl/lag_rule.sv =====
`timescale 1ns / 1ps
// B3/S23 update of one row from its three-row window.
module lag_rule #(
	parameter int W = 64
) (
	input  logic [W-1:0]           above,
	input  logic [W-1:0]           mid,
	input  logic [W-1:0]           below,
	input  logic [$clog2(W+1)-1:0] width,
	input  logic                   wrap,
	output logic [W-1:0]           next
);
	logic [W-1:0] lastm;
	logic         a_last, m_last, b_last;

	always_comb begin
		for (int i = 0; i < W; i++) begin
			lastm[i] = (i == int'(width) - 1);
		end
		a_last = |(above & lastm);
		m_last = |(mid & lastm);
		b_last = |(below & lastm);
	end

	always_comb begin
		logic       al, ml, bl, ar, mr, br;
		logic [3:0] n;
		for (int x = 0; x < W; x++) begin
			if (x == 0) begin
				al = wrap & a_last;
				ml = wrap & m_last;
				bl = wrap & b_last;
			end else begin
				al = above[(x > 0) ? x - 1 : 0];
				ml = mid[(x > 0) ? x - 1 : 0];
				bl = below[(x > 0) ? x - 1 : 0];
			end
			if (x == int'(width) - 1) begin
				ar = wrap & above[0];
				mr = wrap & mid[0];
				br = wrap & below[0];
			end else if (x + 1 < W) begin
				ar = above[(x + 1 < W) ? x + 1 : 0];
				mr = mid[(x + 1 < W) ? x + 1 : 0];
				br = below[(x + 1 < W) ? x + 1 : 0];
			end else begin
				ar = 1'b0;
				mr = 1'b0;
				br = 1'b0;
			end
			n = 4'(al) + 4'(above[x]) + 4'(ar) + 4'(ml) + 4'(mr)
				+ 4'(bl) + 4'(below[x]) + 4'(br);
			next[x] = (x < int'(width)) && ((n == 4'd3) || (mid[x] && n == 4'd2));
		end
	end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import lag_pkg::*;

	localparam int GW = 64;
	localparam int GH = 64;

	class life_scoreboard;
		bit grid [GH][GW];
		int unsigned width_act, height_act;
		bit wrap_on;
		bit q_alive [$];
		bit q_err [$];
		int unsigned mismatches, results_seen;

		function void clear();
			foreach (grid[y, x]) grid[y][x] = 1'b0;
			width_act = GW;
			height_act = GH;
			wrap_on = 1'b0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			int unsigned v;
			v = val;
			if (idx == REG_GRID_WIDTH)
				width_act = (v == 0) ? 1 : (v > GW ? GW : v);
			else if (idx == REG_GRID_HEIGHT)
				height_act = (v == 0) ? 1 : (v > GH ? GH : v);
			else if (idx == REG_WRAP_EDGES)
				wrap_on = val[0];
		endfunction

		function int unsigned neighbours(int unsigned x, int unsigned y);
			int unsigned cnt, nx, ny;
			cnt = 0;
			for (int dy = 0; dy < 3; dy++)
				for (int dx = 0; dx < 3; dx++) begin
					if (dx == 1 && dy == 1) continue;
					if (wrap_on) begin
						nx = (x + dx + width_act - 1) % width_act;
						ny = (y + dy + height_act - 1) % height_act;
					end else begin
						if ((x == 0 && dx == 0) || (y == 0 && dy == 0)) continue;
						nx = x + dx - 1;
						ny = y + dy - 1;
						if (nx >= width_act || ny >= height_act) continue;
					end
					cnt += grid[ny][nx];
				end
			return cnt;
		endfunction

		function void generation();
			bit nxt [GH][GW];
			int unsigned n;
			foreach (nxt[y, x]) nxt[y][x] = 1'b0;
			for (int unsigned y = 0; y < height_act; y++)
				for (int unsigned x = 0; x < width_act; x++) begin
					n = neighbours(x, y);
					nxt[y][x] = (n == 3) || (grid[y][x] && n == 2);
				end
			grid = nxt;
		endfunction

		function void note_input(logic [1:0] f, logic [5:0] x, logic [5:0] y, logic v);
			bit bad, a, e;
			bad = (x >= width_act) || (y >= height_act);
			a = 0;
			e = 0;
			if (f == FN_WRITE) begin
				if (bad) e = 1;
				else begin
					grid[y][x] = v;
					a = v;
				end
			end else if (f == FN_READ) begin
				if (bad) e = 1;
				else a = grid[y][x];
			end else if (f == FN_STEP)
				generation();
			q_alive.push_back(a);
			q_err.push_back(e);
		endfunction

		function void check_result(logic a, logic e);
			bit xa, xe;
			results_seen++;
			if (q_alive.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result alive=%0b err=%0b", a, e);
				return;
			end
			xa = q_alive.pop_front();
			xe = q_err.pop_front();
			if (a !== xa || e !== xe) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected alive=%0b err=%0b, got alive=%0b err=%0b",
						results_seen, xa, xe, a, e);
			end
		endfunction

		function int pending();
			return q_alive.size();
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] func;
	logic [5:0] cell_x, cell_y;
	logic cell_value, cell_alive, coord_error;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_wdata;

	life_scoreboard sb;
	bit src_idle_on, sink_idle_on, hold_long;
	int unsigned sent;

	life_automaton_grid dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("life_automaton_grid: mismatch");
		$finish;
	end

	// result side: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(cell_alive, coord_error);
	end

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				hold_long = 0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic [1:0] f, logic [5:0] x, logic [5:0] y, logic v);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		cell_x <= x;
		cell_y <= y;
		cell_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(f, x, y, v);
		sent++;
	endtask

	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * GH + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// mostly in-range coordinates, some past the active size
	task automatic random_item();
		int r;
		logic [5:0] x, y;
		r = $urandom_range(0, 99);
		x = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, sb.width_act - 1));
		y = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, sb.height_act - 1));
		if (r < 50) send_item(FN_WRITE, x, y, 1'($urandom));
		else if (r < 80) send_item(FN_READ, x, y, 1'($urandom));
		else if (r < 95) send_item(FN_STEP, x, y, 1'($urandom));
		else send_item(FN_UNUSED, x, y, 1'($urandom));
	endtask

	initial begin
		int sizes [8][3];
		sb = new();
		sb.clear();
		arst_n = 0;
		in_valid = 0;
		func = 0;
		cell_x = 0;
		cell_y = 0;
		cell_value = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		src_idle_on = 0;
		sink_idle_on = 0;
		hold_long = 0;
		sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, blinker, out of range, unused code
		send_item(FN_WRITE, 0, 0, 1);
		send_item(FN_WRITE, 63, 63, 1);
		send_item(FN_READ, 63, 63, 0);
		send_item(FN_WRITE, 1, 0, 1);
		send_item(FN_WRITE, 2, 0, 1);
		send_item(FN_STEP, 0, 0, 0);
		send_item(FN_READ, 1, 1, 0);
		send_item(FN_WRITE, 63, 63, 0);
		send_item(FN_UNUSED, 63, 0, 1);
		drain();
		write_reg(REG_GRID_WIDTH, 7'd10);
		write_reg(REG_GRID_HEIGHT, 7'd5);
		write_reg(REG_WRAP_EDGES, 7'd1);
		send_item(FN_WRITE, 10, 2, 1);
		send_item(FN_READ, 3, 5, 0);
		send_item(FN_WRITE, 9, 4, 1);
		send_item(FN_WRITE, 0, 4, 1);
		send_item(FN_WRITE, 9, 0, 1);
		send_item(FN_STEP, 0, 0, 0);
		send_item(FN_READ, 0, 0, 0);
		send_item(FN_READ, 9, 4, 0);
		drain();
		write_reg(REG_GRID_WIDTH, 7'd0);
		write_reg(REG_GRID_HEIGHT, 7'd127);
		send_item(FN_WRITE, 0, 7, 1);
		send_item(FN_STEP, 0, 0, 0);
		send_item(FN_READ, 0, 7, 0);
		drain();

		sizes = '{'{64, 64, 0}, '{1, 1, 1}, '{2, 2, 1}, '{3, 3, 0}, '{8, 6, 1},
			'{64, 64, 1}, '{17, 40, 0}, '{5, 64, 1}};
		src_idle_on = 1;
		sink_idle_on = 1;
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_GRID_WIDTH, 7'(sizes[p][0]));
			write_reg(REG_GRID_HEIGHT, 7'(sizes[p][1]));
			write_reg(REG_WRAP_EDGES, 7'(sizes[p][2]));
			if (p == 2) hold_long = 1;
			if (p == 7) begin
				src_idle_on = 0;
				sink_idle_on = 0;
			end
			repeat (235) random_item();
			drain();
		end
		$display("ran %0d transfers over 11 grid settings, wrap and dead edges, with stalls",
			sent);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("life_automaton_grid: match");
		else
			$display("life_automaton_grid: mismatch");
		$finish;
	end
endmodule
